[hw/rtl/gld_pkg.sv]
`timescale 1ns / 1ps
// shared constants, codes and control types of the gif lzw decoder
// no dependencies
package gld_pkg;

    // code and table geometry
    localparam int CODE_BITS           = 12;
    localparam int TABLE_ENTRIES_DEF   = 4096;
    localparam int BIT_BUFFER_BITS_DEF = 32;
    localparam int STACK_SIZE          = 4097;
    localparam int DEPTH_BITS          = 13;
    localparam int FREE_BITS           = 13;

    // item kinds
    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_PULL    = 2'd1;
    localparam logic [1:0] KIND_RESTART = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_STARVED  = 3'd2;
    localparam logic [2:0] ST_END      = 3'd3;
    localparam logic [2:0] ST_CIRCULAR = 3'd4;

    localparam logic [3:0] MIN_SIZE_RESET = 4'd8;

    // outcome of one decode step
    typedef enum logic [2:0] {
        DEC_STARVED,
        DEC_END,
        DEC_CLEAR,
        DEC_FIRST,
        DEC_WALK
    } gld_dec_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic pop;
        logic dec_step;
        logic walk_ex;
        logic finish;
        logic load_out;
    } gld_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic     stk_empty;
        gld_dec_t dec;
        logic     walk_more;
        logic     walk_circ;
        logic     out_free;
    } gld_stat_t;

endpackage

[hw/rtl/gld_item_if.sv]
`timescale 1ns / 1ps
// input word channel: kind and code stream byte
// no dependencies
interface gld_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;

    modport source(output valid, output kind, output data_byte, input ready);
    modport sink(input valid, input kind, input data_byte, output ready);
endinterface

[hw/rtl/gld_result_if.sv]
`timescale 1ns / 1ps
// output word channel: palette index and status
// no dependencies
interface gld_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_index;
    logic [2:0] status;

    modport source(output valid, output pixel_index, output status, input ready);
    modport sink(input valid, input pixel_index, input status, output ready);
endinterface

[hw/rtl/gld_cfg_if.sv]
`timescale 1ns / 1ps
// configuration write channel for the minimum code size register
// no dependencies
interface gld_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] min_code_size;

    modport source(output valid, output min_code_size, input ready);
    modport sink(input valid, input min_code_size, output ready);
endinterface

[hw/rtl/gif_lzw_decoder.sv]
`timescale 1ns / 1ps
// GIF LZW decoder, 12-bit variable width codes, one word in and one result out.
// A push, restart or unused word goes from accept through S_RESP to the result register; a pull
// served from pending pixels passes S_POP first. A pull that ends on a first code, an end code or
// a short buffer runs S_DEC once plus once per clear code skipped; a pull that walks the code
// chain then runs S_WRD and S_WEX for each link and S_FIN unless the chain is circular, the
// chain walk reading one prefix/suffix table entry per link from block memory.
// A result waits in its own output register, so the next word is taken while
// it is still unread. No clearing pass runs after reset.
// depends on gld_pkg, gld_item_if, gld_result_if, gld_cfg_if, gld_ctrl, gld_datapath
module gif_lzw_decoder #(
    parameter int TABLE_ENTRIES   = gld_pkg::TABLE_ENTRIES_DEF,
    parameter int BIT_BUFFER_BITS = gld_pkg::BIT_BUFFER_BITS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    gld_cfg_if.sink      cfg,
    gld_item_if.sink     item,
    gld_result_if.source result
);
    import gld_pkg::*;

    gld_cmd_t  cmd;
    gld_stat_t stat;

    // configuration is always taken
    assign cfg.ready = 1'b1;

    // sequencer
    gld_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_kind  (item.kind),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    gld_datapath #(
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .BIT_BUFFER_BITS (BIT_BUFFER_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg.valid),
        .cfg_min    (cfg.min_code_size),
        .item_kind  (item.kind),
        .item_byte  (item.data_byte),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .out_pix    (result.pixel_index),
        .out_status (result.status)
    );

endmodule

[hw/rtl/gld_ctrl.sv]
`timescale 1ns / 1ps
// sequencer of the gif lzw decoder: accept, pop, decode, chain walk, respond
// depends on gld_pkg
module gld_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          in_kind,
    output logic                in_ready,
    input  gld_pkg::gld_stat_t  stat,
    output gld_pkg::gld_cmd_t   cmd
);
    import gld_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_POP  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_WRD  = 3'd3;
    localparam logic [2:0] S_WEX  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_RESP = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_kind == KIND_PULL)
                        state_next = stat.stk_empty ? S_DEC : S_POP;
                    else
                        state_next = S_RESP;
                end
            end
            S_POP:
            begin
                cmd.pop    = 1'b1;
                state_next = S_RESP;
            end
            S_DEC:
            begin
                cmd.dec_step = 1'b1;
                case (stat.dec)
                    DEC_CLEAR: state_next = S_DEC;
                    DEC_WALK:  state_next = S_WRD;
                    default:   state_next = S_RESP;
                endcase
            end
            S_WRD:
            begin
                // table read of the current chain link is issued here
                state_next = stat.walk_more ? S_WEX : S_FIN;
            end
            S_WEX:
            begin
                cmd.walk_ex = 1'b1;
                state_next  = stat.walk_circ ? S_RESP : S_WRD;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

[hw/rtl/gld_datapath.sv]
`timescale 1ns / 1ps
// bit buffer, code tables, pixel stack and result registers of the decoder
// depends on gld_pkg
module gld_datapath #(
    parameter int TABLE_ENTRIES   = gld_pkg::TABLE_ENTRIES_DEF,
    parameter int BIT_BUFFER_BITS = gld_pkg::BIT_BUFFER_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  gld_pkg::gld_cmd_t  cmd,
    output gld_pkg::gld_stat_t stat,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_min,
    input  logic [1:0]         item_kind,
    input  logic [7:0]         item_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_pix,
    output logic [2:0]         out_status
);
    import gld_pkg::*;

    localparam int TW  = $clog2(TABLE_ENTRIES);
    localparam int BHW = $clog2(BIT_BUFFER_BITS + 1);

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_ENDED = 2'd3;

    // memories
    logic [CODE_BITS-1:0] prefix_mem [0:TABLE_ENTRIES-1];
    logic [7:0]           suffix_mem [0:TABLE_ENTRIES-1];
    logic [7:0]           stack_mem  [0:STACK_SIZE-1];
    logic [CODE_BITS-1:0] prefix_q;
    logic [7:0]           suffix_q;
    logic [7:0]           stack_q;

    // registers
    logic [3:0]                 min_size_reg,   min_size_next;
    logic [3:0]                 active_min_reg, active_min_next;
    logic [BIT_BUFFER_BITS-1:0] buf_reg,        buf_next;
    logic [BHW-1:0]             bits_reg,       bits_next;
    logic [3:0]                 cw_reg,         cw_next;
    logic [FREE_BITS-1:0]       nf_reg,         nf_next;
    logic [FREE_BITS-1:0]       wl_reg,         wl_next;
    logic [CODE_BITS-1:0]       prev_reg,       prev_next;
    logic [7:0]                 first_reg,      first_next;
    logic [1:0]                 phase_reg,      phase_next;
    logic [DEPTH_BITS-1:0]      depth_reg,      depth_next;
    logic [CODE_BITS-1:0]       walk_reg,       walk_next;
    logic [CODE_BITS-1:0]       code_reg,       code_next;
    logic [7:0]                 res_pix_reg,    res_pix_next;
    logic [2:0]                 res_st_reg,     res_st_next;
    logic                       out_valid_reg,  out_valid_next;
    logic [7:0]                 out_pix_reg,    out_pix_next;
    logic [2:0]                 out_st_reg,     out_st_next;

    // decode helpers
    logic [FREE_BITS-1:0]       cc;
    logic [CODE_BITS-1:0]       code_mask;
    logic [CODE_BITS-1:0]       code_raw;
    logic [FREE_BITS-1:0]       code_ext;
    logic [FREE_BITS-1:0]       walk_ext;
    logic [FREE_BITS-1:0]       nf_inc;
    logic                       starved;
    logic                       buf_full;
    logic [3:0]                 min_clamped;
    logic                       ent_ok;
    logic [CODE_BITS-1:0]       ent_prefix;
    logic [7:0]                 ent_suffix;
    logic                       depth_full;
    logic                       tab_we;
    logic                       stk_we;
    logic [7:0]                 stk_wdata;
    logic [BIT_BUFFER_BITS-1:0] byte_shifted;
    gld_dec_t                   dec;

    assign cc        = FREE_BITS'(1) << active_min_reg;
    assign code_mask = (CODE_BITS'(1) << cw_reg) - CODE_BITS'(1);
    assign code_raw  = buf_reg[CODE_BITS-1:0] & code_mask;
    assign code_ext  = {1'b0, code_raw};
    assign walk_ext  = {1'b0, walk_reg};
    assign nf_inc    = nf_reg + FREE_BITS'(1);
    assign starved   = bits_reg < {{(BHW-4){1'b0}}, cw_reg};
    assign buf_full  = ({1'b0, bits_reg} + (BHW+1)'(8)) > (BHW+1)'(BIT_BUFFER_BITS);
    assign depth_full = depth_reg >= DEPTH_BITS'(STACK_SIZE);
    assign byte_shifted = {{(BIT_BUFFER_BITS-8){1'b0}}, item_byte} << bits_reg;

    // out of range sizes are pinned to the legal span
    always_comb
    begin
        if (min_size_reg < 4'd2)
            min_clamped = 4'd2;
        else if (min_size_reg > 4'd8)
            min_clamped = 4'd8;
        else
            min_clamped = min_size_reg;
    end

    // only entries added since the last clear are read from memory
    assign ent_ok     = (walk_ext < nf_reg) && (walk_ext >= cc + FREE_BITS'(2));
    assign ent_prefix = ent_ok ? prefix_q : '0;
    assign ent_suffix = ent_ok ? suffix_q : 8'd0;

    // decode step outcome
    always_comb
    begin
        if (phase_reg == PH_ENDED)
            dec = DEC_END;
        else if (starved)
            dec = DEC_STARVED;
        else if (code_ext == cc)
            dec = DEC_CLEAR;
        else if (code_ext == cc + FREE_BITS'(1))
            dec = DEC_END;
        else if (phase_reg == PH_FIRST)
            dec = DEC_FIRST;
        else
            dec = DEC_WALK;
    end

    assign stat.stk_empty = (depth_reg == '0);
    assign stat.dec       = dec;
    assign stat.walk_more = walk_ext >= cc;
    assign stat.walk_circ = depth_full || (ent_prefix == walk_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign tab_we = cmd.finish && !depth_full && (nf_reg < FREE_BITS'(TABLE_ENTRIES));

    // next state of the datapath
    always_comb
    begin
        min_size_next   = min_size_reg;
        active_min_next = active_min_reg;
        buf_next        = buf_reg;
        bits_next       = bits_reg;
        cw_next         = cw_reg;
        nf_next         = nf_reg;
        wl_next         = wl_reg;
        prev_next       = prev_reg;
        first_next      = first_reg;
        phase_next      = phase_reg;
        depth_next      = depth_reg;
        walk_next       = walk_reg;
        code_next       = code_reg;
        res_pix_next    = res_pix_reg;
        res_st_next     = res_st_reg;
        out_valid_next  = out_valid_reg;
        out_pix_next    = out_pix_reg;
        out_st_next     = out_st_reg;
        stk_we          = 1'b0;
        stk_wdata       = first_reg;

        if (cfg_we)
            min_size_next = cfg_min;

        // output register
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            out_pix_next   = res_pix_reg;
            out_st_next    = res_st_reg;
        end

        // accepted word
        if (cmd.accept)
        begin
            res_pix_next = 8'd0;
            res_st_next  = ST_OK;
            case (item_kind)
                KIND_PUSH:
                begin
                    if (buf_full)
                        res_st_next = ST_FULL;
                    else
                    begin
                        buf_next  = buf_reg | byte_shifted;
                        bits_next = bits_reg + BHW'(8);
                    end
                end
                KIND_PULL:
                begin
                    if (depth_reg != '0)
                        depth_next = depth_reg - DEPTH_BITS'(1);
                end
                KIND_RESTART:
                begin
                    active_min_next = min_clamped;
                    cw_next         = min_clamped + 4'd1;
                    nf_next         = (FREE_BITS'(1) << min_clamped) + FREE_BITS'(2);
                    wl_next         = FREE_BITS'(1) << (min_clamped + 4'd1);
                    depth_next      = '0;
                    buf_next        = '0;
                    bits_next       = '0;
                    prev_next       = '0;
                    first_next      = 8'd0;
                    phase_next      = PH_FIRST;
                end
                default:
                begin
                end
            endcase
        end

        // pop of a pending pixel
        if (cmd.pop)
        begin
            res_pix_next = stack_q;
            res_st_next  = ST_OK;
        end

        // one code from the bit buffer
        if (cmd.dec_step)
        begin
            res_pix_next = 8'd0;
            if (dec != DEC_STARVED && phase_reg != PH_ENDED)
            begin
                buf_next  = buf_reg >> cw_reg;
                bits_next = bits_reg - {{(BHW-4){1'b0}}, cw_reg};
            end
            case (dec)
                DEC_STARVED: res_st_next = ST_STARVED;
                DEC_END:
                begin
                    res_st_next = ST_END;
                    phase_next  = PH_ENDED;
                end
                DEC_CLEAR:
                begin
                    cw_next    = active_min_reg + 4'd1;
                    nf_next    = cc + FREE_BITS'(2);
                    wl_next    = cc << 1;
                    depth_next = '0;
                    phase_next = PH_FIRST;
                end
                DEC_FIRST:
                begin
                    first_next   = code_raw[7:0];
                    prev_next    = code_raw;
                    phase_next   = PH_RUN;
                    res_pix_next = code_raw[7:0];
                    res_st_next  = ST_OK;
                end
                DEC_WALK:
                begin
                    code_next = code_raw;
                    if (code_ext >= nf_reg)
                    begin
                        stk_we     = 1'b1;
                        stk_wdata  = first_reg;
                        depth_next = depth_reg + DEPTH_BITS'(1);
                        walk_next  = prev_reg;
                    end
                    else
                        walk_next = code_raw;
                end
                default:
                begin
                end
            endcase
        end

        // one link of the chain
        if (cmd.walk_ex)
        begin
            if (depth_full || ent_prefix == walk_reg)
            begin
                depth_next   = '0;
                res_pix_next = 8'd0;
                res_st_next  = ST_CIRCULAR;
            end
            else
            begin
                stk_we     = 1'b1;
                stk_wdata  = ent_suffix;
                depth_next = depth_reg + DEPTH_BITS'(1);
                walk_next  = ent_prefix;
            end
        end

        // root reached: add entry if there is room, emit first symbol; a full stack reports circular
        if (cmd.finish)
        begin
            if (depth_full)
            begin
                depth_next   = '0;
                res_pix_next = 8'd0;
                res_st_next  = ST_CIRCULAR;
            end
            else
            begin
                first_next = walk_reg[7:0];
                if (nf_reg < FREE_BITS'(TABLE_ENTRIES))
                begin
                    nf_next = nf_inc;
                    if (nf_inc >= wl_reg && wl_reg < FREE_BITS'(TABLE_ENTRIES))
                    begin
                        wl_next = wl_reg << 1;
                        cw_next = cw_reg + 4'd1;
                    end
                end
                prev_next    = code_reg;
                res_pix_next = walk_reg[7:0];
                res_st_next  = ST_OK;
            end
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_size_reg   <= MIN_SIZE_RESET;
            active_min_reg <= MIN_SIZE_RESET;
            buf_reg        <= '0;
            bits_reg       <= '0;
            cw_reg         <= MIN_SIZE_RESET + 4'd1;
            nf_reg         <= (FREE_BITS'(1) << MIN_SIZE_RESET) + FREE_BITS'(2);
            wl_reg         <= FREE_BITS'(1) << (MIN_SIZE_RESET + 4'd1);
            prev_reg       <= '0;
            first_reg      <= 8'd0;
            phase_reg      <= PH_FIRST;
            depth_reg      <= '0;
            walk_reg       <= '0;
            code_reg       <= '0;
            res_pix_reg    <= 8'd0;
            res_st_reg     <= ST_OK;
            out_valid_reg  <= 1'b0;
            out_pix_reg    <= 8'd0;
            out_st_reg     <= ST_OK;
        end
        else
        begin
            min_size_reg   <= min_size_next;
            active_min_reg <= active_min_next;
            buf_reg        <= buf_next;
            bits_reg       <= bits_next;
            cw_reg         <= cw_next;
            nf_reg         <= nf_next;
            wl_reg         <= wl_next;
            prev_reg       <= prev_next;
            first_reg      <= first_next;
            phase_reg      <= phase_next;
            depth_reg      <= depth_next;
            walk_reg       <= walk_next;
            code_reg       <= code_next;
            res_pix_reg    <= res_pix_next;
            res_st_reg     <= res_st_next;
            out_valid_reg  <= out_valid_next;
            out_pix_reg    <= out_pix_next;
            out_st_reg     <= out_st_next;
        end
    end

    // code tables, read at the current chain link
    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            prefix_mem[nf_reg[TW-1:0]] <= prev_reg;
            suffix_mem[nf_reg[TW-1:0]] <= walk_reg[7:0];
        end
        prefix_q <= prefix_mem[walk_reg[TW-1:0]];
        suffix_q <= suffix_mem[walk_reg[TW-1:0]];
    end

    // pixel stack, read at the top entry
    always_ff @(posedge clk)
    begin
        if (stk_we)
            stack_mem[depth_reg] <= stk_wdata;
        stack_q <= stack_mem[depth_reg - DEPTH_BITS'(1)];
    end

    assign out_valid  = out_valid_reg;
    assign out_pix    = out_pix_reg;
    assign out_status = out_st_reg;

endmodule

[tb/gif_lzw_decoder_test.sv]
`timescale 1ns / 1ps
// self-checking testbench of the gif lzw decoder: random lzw code streams, byte
// pushes, pixel pulls and restarts, checked against a scoreboard that decodes in step
// depends on gld_pkg, gld_item_if, gld_result_if, gld_cfg_if and gif_lzw_decoder
module gif_lzw_decoder_test;
    import gld_pkg::*;

    localparam int TBL = 4096;
    localparam int BUF_BITS = 32;
    localparam int PH_FIRST = 0;
    localparam int PH_RUN = 1;
    localparam int PH_ENDED = 3;
    localparam int NUM_PHASES = 9;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // decoding scoreboard: mirrors decoder state and holds expected result words
    class LzwScoreboard;
        bit [11:0] prefix_tbl [TBL];
        bit [7:0]  suffix_tbl [TBL];
        bit [7:0]  pend [STACK_SIZE];
        int        depth, bits_held, code_width, next_free, width_limit;
        int        prev_code, phase, min_size, active_min;
        bit [7:0]  first_sym;
        bit [63:0] bit_buf;
        bit [10:0] want_q [$];
        int        mismatches, checked, pixels_ok;
        int        status_seen [8];

        function new();
            min_size = MIN_SIZE_RESET;
            restart();
        endfunction

        function void reset_table();
            int cc;
            cc = 1 << active_min;
            for (int i = 0; i < TBL; i++)
            begin
                prefix_tbl[i] = 0;
                suffix_tbl[i] = (i < cc) ? i[7:0] : 8'd0;
            end
            code_width = active_min + 1;
            next_free = cc + 2;
            width_limit = cc << 1;
            depth = 0;
        endfunction

        function void restart();
            active_min = (min_size < 2) ? 2 : ((min_size > 8) ? 8 : min_size);
            reset_table();
            bit_buf = 0;
            bits_held = 0;
            prev_code = 0;
            first_sym = 0;
            phase = PH_FIRST;
        endfunction

        function int rd_prefix(int c);
            return (c < TBL) ? int'(prefix_tbl[c]) : 0;
        endfunction

        function bit [7:0] rd_suffix(int c);
            return (c < TBL) ? suffix_tbl[c] : 8'd0;
        endfunction

        // one pull: pop a pending pixel or decode the next code
        function bit [2:0] pull_pixel(output bit [7:0] pix);
            int cc, code, walk;
            pix = 0;
            cc = 1 << active_min;
            if (depth > 0)
            begin
                depth--;
                pix = pend[depth];
                return ST_OK;
            end
            while (1)
            begin
                if (phase == PH_ENDED)
                    return ST_END;
                if (bits_held < code_width)
                    return ST_STARVED;
                code = int'(bit_buf & ((64'd1 << code_width) - 1));
                bit_buf >>= code_width;
                bits_held -= code_width;
                if (code == cc)
                begin
                    reset_table();
                    phase = PH_FIRST;
                    continue;
                end
                if (code == cc + 1)
                begin
                    phase = PH_ENDED;
                    return ST_END;
                end
                if (phase == PH_FIRST)
                begin
                    first_sym = code[7:0];
                    prev_code = code;
                    phase = PH_RUN;
                    pix = code[7:0];
                    return ST_OK;
                end
                break;
            end
            // chain walk, code-equals-next-entry case first
            walk = code;
            if (code >= next_free)
            begin
                pend[depth] = first_sym;
                depth++;
                walk = prev_code;
            end
            while (walk >= cc)
            begin
                if (depth >= STACK_SIZE || rd_prefix(walk) == walk)
                begin
                    depth = 0;
                    return ST_CIRCULAR;
                end
                pend[depth] = rd_suffix(walk);
                depth++;
                walk = rd_prefix(walk);
            end
            if (depth >= STACK_SIZE)
            begin
                depth = 0;
                return ST_CIRCULAR;
            end
            first_sym = rd_suffix(walk);
            pend[depth] = first_sym;
            depth++;
            if (next_free < TBL)
            begin
                prefix_tbl[next_free] = prev_code[11:0];
                suffix_tbl[next_free] = first_sym;
                next_free++;
                if (next_free >= width_limit && width_limit < TBL)
                begin
                    width_limit <<= 1;
                    code_width++;
                end
            end
            prev_code = code;
            depth--;
            pix = pend[depth];
            return ST_OK;
        endfunction

        // accepted input word: advance state, queue expected result
        function void note_word(bit [1:0] kind, bit [7:0] data);
            bit [2:0] st;
            bit [7:0] pix;
            st = ST_OK;
            pix = 0;
            if (kind == KIND_PUSH)
            begin
                if (bits_held + 8 > BUF_BITS)
                    st = ST_FULL;
                else
                begin
                    bit_buf |= 64'(data) << bits_held;
                    bits_held += 8;
                end
            end
            else if (kind == KIND_PULL)
            begin
                st = pull_pixel(pix);
                if (st != ST_OK)
                    pix = 0;
            end
            else if (kind == KIND_RESTART)
                restart();
            want_q.push_back({pix, st});
        endfunction

        // accepted result word: compare with oldest expectation
        function void check_result(bit [7:0] pix, bit [2:0] st);
            bit [10:0] want;
            checked++;
            if (want_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: pixel %0d status %0d", pix, st);
                return;
            end
            want = want_q.pop_front();
            status_seen[want[2:0]]++;
            if (want[2:0] == ST_OK && pix != 0)
                pixels_ok++;
            if (want[10:3] != pix || want[2:0] != st)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d mismatch: expected pixel %0d status %0d, got %0d %0d",
                             checked, want[10:3], want[2:0], pix, st);
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    int   send_idle = 13;
    int   recv_idle = 88;
    int   words_sent = 0;
    int   cfg_writes = 0;

    // code stream generator state
    bit [7:0]  byte_q [$];
    bit [63:0] acc;
    int        acc_bits, g_cc, g_next, g_limit, g_width;

    LzwScoreboard sb;

    gld_cfg_if    cfg_ch();
    gld_item_if   item_ch();
    gld_result_if res_ch();

    gif_lzw_decoder uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .item   (item_ch),
        .result (res_ch)
    );

    always #6 clk = ~clk;

    // receiver stalls and result monitor
    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.pixel_index, res_ch.status);
    end

    // one input word with random sender gaps
    task automatic send_word(bit [1:0] kind, bit [7:0] data);
        while ($urandom_range(99) < send_idle)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.kind <= kind;
        item_ch.data_byte <= data;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_word(kind, data);
        words_sent++;
    endtask

    // register write while the decoder is idle
    task automatic write_min_size(bit [3:0] val);
        item_ch.valid <= 1'b0;
        while (sb.want_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.min_code_size <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.min_size = val;
        cfg_writes++;
    endtask

    function automatic void gen_reset();
        g_cc = 1 << sb.active_min;
        g_next = g_cc + 2;
        g_limit = g_cc << 1;
        g_width = sb.active_min + 1;
    endfunction

    // append one code lsb first, track table growth as the decoder sees it
    function automatic void emit_code(int c, bit adds);
        acc |= 64'(c) << acc_bits;
        acc_bits += g_width;
        while (acc_bits >= 8)
        begin
            byte_q.push_back(acc[7:0]);
            acc >>= 8;
            acc_bits -= 8;
        end
        if (adds && g_next < TBL)
        begin
            g_next++;
            if (g_next >= g_limit && g_limit < TBL)
            begin
                g_limit <<= 1;
                g_width++;
            end
        end
    endfunction

    // feed queued bytes and pull pixels until nothing more can be decoded
    task automatic drain_stream();
        bit room;
        while (byte_q.size() != 0 || sb.depth > 0
               || (sb.bits_held >= sb.code_width && sb.phase != PH_ENDED))
        begin
            room = (sb.bits_held + 8 <= BUF_BITS);
            if (sb.phase == PH_ENDED && sb.depth == 0)
                byte_q.delete();
            else if ($urandom_range(99) < 2)
                send_word($urandom_range(99) < 50 ? KIND_UNUSED : KIND_PUSH, 8'($urandom));
            else if (byte_q.size() != 0 && room
                     && (sb.bits_held < sb.code_width || $urandom_range(3) != 0))
                send_word(KIND_PUSH, byte_q.pop_front());
            else
                send_word(KIND_PULL, 8'($urandom));
        end
        // a trailing pull sees starvation or the end code
        send_word(KIND_PULL, 8'($urandom));
    endtask

    // one image: restart, optional leading clears, codes, optional end code
    task automatic run_image(int n_codes, int lead_clears, bit odd_first, bit end_only);
        int r;
        bit first;
        send_word(KIND_RESTART, 8'($urandom));
        gen_reset();
        acc = 0;
        acc_bits = 0;
        for (int i = 0; i < lead_clears; i++)
            emit_code(g_cc, 0);
        if (end_only)
            emit_code(g_cc + 1, 0);
        else
        begin
            // non-root first code is decoded as its low byte
            emit_code(odd_first ? $urandom_range(g_cc + 2, (1 << g_width) - 1)
                                : $urandom_range(g_cc - 1), 0);
            first = 0;
            for (int i = 1; i < n_codes; i++)
            begin
                r = $urandom_range(99);
                if (first)
                begin
                    emit_code($urandom_range(g_cc - 1), 0);
                    first = 0;
                end
                else if (r < 3)
                begin
                    // clear code, sometimes twice in a row
                    emit_code(g_cc, 0);
                    if (r == 0)
                        emit_code(g_cc, 0);
                    gen_reset();
                    first = 1;
                end
                else if (r < 6 && g_next < (1 << g_width) - 1)
                    emit_code($urandom_range(g_next + 1, (1 << g_width) - 1), 1);
                else if (r < 50)
                    emit_code($urandom_range(g_cc - 1), 1);
                else
                    emit_code($urandom_range(g_cc + 2, (g_next < TBL) ? g_next : TBL - 1), 1);
            end
            if ($urandom_range(99) < 80)
                emit_code(g_cc + 1, 0);
        end
        if (acc_bits > 0)
            byte_q.push_back(acc[7:0]);
        drain_stream();
    endtask

    initial
    begin
        bit [3:0] sizes [NUM_PHASES] = '{4'd8, 4'd2, 4'd0, 4'd15, 4'd5, 4'd3, 4'd7, 4'd4, 4'd6};
        int mode, target;
        sb = new();
        item_ch.valid = 0;
        item_ch.kind = KIND_PUSH;
        item_ch.data_byte = 0;
        cfg_ch.valid = 0;
        cfg_ch.min_code_size = MIN_SIZE_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: unused kind, starved pull, buffer overflow, extreme bytes
        send_word(KIND_UNUSED, 8'hAA);
        send_word(KIND_PULL, 8'h00);
        send_word(KIND_RESTART, 8'hFF);
        send_word(KIND_PUSH, 8'hFF);
        send_word(KIND_PUSH, 8'h00);
        send_word(KIND_PUSH, 8'hFF);
        send_word(KIND_PUSH, 8'h00);
        send_word(KIND_PUSH, 8'h55);
        repeat (4) send_word(KIND_PULL, 8'h00);
        // directed images: leading clears, non-root first, end code first
        run_image(4, 2, 0, 0);
        run_image(3, 0, 1, 0);
        run_image(1, 0, 0, 1);

        // random phases across settings and idle modes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            mode = p * 3 / NUM_PHASES;
            send_idle = (mode == 0) ? 13 : ((mode == 1) ? 88 : 0);
            recv_idle = (mode == 0) ? 88 : ((mode == 1) ? 13 : 0);
            write_min_size(sizes[p]);
            target = words_sent + 60;
            while (words_sent < target)
                run_image(($urandom_range(9) == 0) ? 40 : $urandom_range(3, 12),
                          $urandom_range(3) == 0 ? $urandom_range(1, 2) : 0,
                          $urandom_range(19) == 0, $urandom_range(29) == 0);
        end
        item_ch.valid <= 1'b0;

        // wait out the remaining results
        while (sb.want_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        $display("%0d words sent, %0d results checked, %0d register writes",
                 words_sent, sb.checked, cfg_writes);
        $display("non-zero pixels %0d, full %0d, starved %0d, end %0d, circular %0d",
                 sb.pixels_ok, sb.status_seen[ST_FULL], sb.status_seen[ST_STARVED],
                 sb.status_seen[ST_END], sb.status_seen[ST_CIRCULAR]);
        if (sb.mismatches == 0 && sb.want_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // run time limit
    initial
    begin
        #60ms;
        $display("Some tests failed");
        $finish;
    end
endmodule

[gif_lzw_decoder.f]
hw/rtl/gld_pkg.sv
hw/rtl/gld_item_if.sv
hw/rtl/gld_result_if.sv
hw/rtl/gld_cfg_if.sv
hw/rtl/gld_ctrl.sv
hw/rtl/gld_datapath.sv
hw/rtl/gif_lzw_decoder.sv
tb/gif_lzw_decoder_test.sv
